@@ rtl/life_generation_engine_top_assert.svh @@
// assertion macros for the life generation engine
// used by the controller; expects clock and reset in scope
`ifndef LIFE_GENERATION_ENGINE_TOP_ASSERT_SVH
`define LIFE_GENERATION_ENGINE_TOP_ASSERT_SVH
// same-cycle implication
`define LGE_ASSERT_IMPLY(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("lge check failed");
// next-cycle implication
`define LGE_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("lge check failed");
`endif

@@ rtl/lge_pkg.sv @@
// shared types and constants for the life generation engine
// no dependencies
package lge_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = ROW_BITS + 1;
   localparam int DIM_BITS   = 8;
   localparam int CNT_BITS   = 15;
   localparam int MIN_DIM    = 3;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_READ = 2'd1,
      OP_STEP = 2'd2
   } op_type;

   typedef enum logic {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      RSEL_ACCESS,
      RSEL_UP,
      RSEL_MID,
      RSEL_DN,
      RSEL_DST
   } rsel_type;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_UP,
      CAP_MID,
      CAP_DN,
      CAP_DST
   } cap_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_RD_UP,
      ST_RD_MID,
      ST_RD_DN,
      ST_RD_DST,
      ST_RD_LAST,
      ST_CELL,
      ST_WRITE,
      ST_SCALE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] col;
      logic [6:0] row;
      logic       cell_in;
   } req_type;

   typedef struct packed {
      logic        read_value;
      logic [14:0] change_count;
      logic        reseed_wanted;
   } rsp_type;

   typedef struct packed {
      logic     req_take;
      logic     rd_en;
      rsel_type rd_sel;
      cap_type  cap_sel;
      logic     cell_en;
      logic     row_wr;
      logic     acc_wr;
      logic     scale_en;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       x_last;
      logic       y_last;
      logic       rsp_free;
   } sts_type;

endpackage

@@ rtl/lge_ctrl.sv @@
// sequencer for load, read and generation step
// depends on lge_pkg and life_generation_engine_top_assert.svh
`include "life_generation_engine_top_assert.svh"
module lge_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lge_pkg::sts_type sts,
   output lge_pkg::cmd_type cmd
);

   lge_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lge_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lge_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (sts.req_op)
                  lge_pkg::OP_LOAD: state_in = lge_pkg::ST_ACCESS;
                  lge_pkg::OP_READ: state_in = lge_pkg::ST_ACCESS;
                  lge_pkg::OP_STEP: state_in = lge_pkg::ST_RD_UP;
                  default:          state_in = lge_pkg::ST_RESP;
               endcase
            end
         end
         lge_pkg::ST_ACCESS:  state_in = lge_pkg::ST_RESP;
         lge_pkg::ST_RD_UP:   state_in = lge_pkg::ST_RD_MID;
         lge_pkg::ST_RD_MID:  state_in = lge_pkg::ST_RD_DN;
         lge_pkg::ST_RD_DN:   state_in = lge_pkg::ST_RD_DST;
         lge_pkg::ST_RD_DST:  state_in = lge_pkg::ST_RD_LAST;
         lge_pkg::ST_RD_LAST: state_in = lge_pkg::ST_CELL;
         lge_pkg::ST_CELL: begin
            if (sts.x_last) state_in = lge_pkg::ST_WRITE;
         end
         lge_pkg::ST_WRITE: begin
            state_in = sts.y_last ? lge_pkg::ST_SCALE : lge_pkg::ST_RD_UP;
         end
         lge_pkg::ST_SCALE: state_in = lge_pkg::ST_RESP;
         lge_pkg::ST_RESP: begin
            if (sts.rsp_free) state_in = lge_pkg::ST_IDLE;
         end
         default: state_in = lge_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      cmd.rd_sel = lge_pkg::RSEL_ACCESS;
      cmd.cap_sel = lge_pkg::CAP_NONE;
      case (state_ff)
         lge_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.req_take = req_valid && !reset;
            cmd.rd_en = req_valid && !reset;
         end
         lge_pkg::ST_ACCESS: cmd.acc_wr = 1'b1;
         lge_pkg::ST_RD_UP: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = lge_pkg::RSEL_UP;
         end
         lge_pkg::ST_RD_MID: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = lge_pkg::RSEL_MID;
            cmd.cap_sel = lge_pkg::CAP_UP;
         end
         lge_pkg::ST_RD_DN: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = lge_pkg::RSEL_DN;
            cmd.cap_sel = lge_pkg::CAP_MID;
         end
         lge_pkg::ST_RD_DST: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = lge_pkg::RSEL_DST;
            cmd.cap_sel = lge_pkg::CAP_DN;
         end
         lge_pkg::ST_RD_LAST: cmd.cap_sel = lge_pkg::CAP_DST;
         lge_pkg::ST_CELL:    cmd.cell_en = 1'b1;
         lge_pkg::ST_WRITE:   cmd.row_wr = 1'b1;
         lge_pkg::ST_SCALE:   cmd.scale_en = 1'b1;
         lge_pkg::ST_RESP:    cmd.rsp_load = sts.rsp_free;
         default: begin
         end
      endcase
   end

   `LGE_ASSERT_IMPLY(a_rsp_load_free, cmd.rsp_load, sts.rsp_free)
   `LGE_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)
   `LGE_ASSERT_NEXT(a_row_done, cmd.cell_en && sts.x_last, cmd.row_wr)
   `LGE_ASSERT_IMPLY(a_no_overlap, cmd.row_wr, !cmd.cell_en && !cmd.rd_en)

endmodule

@@ rtl/lge_datapath.sv @@
// row store, row buffers, cell update, counters and result register
// depends on lge_pkg
module lge_datapath (
   input  logic             clock,
   input  logic             reset,
   input  lge_pkg::req_type req_payload,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [7:0]       csr_write_data,
   input  lge_pkg::cmd_type cmd,
   output lge_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lge_pkg::rsp_type rsp_payload
);

   localparam int ROWS = 2 * lge_pkg::MAX_HEIGHT;

   logic [lge_pkg::DIM_BITS-1:0] width_ff, height_ff, w, h;
   logic                         bank_ff;
   lge_pkg::req_type             req_ff;
   logic [lge_pkg::MAX_WIDTH-1:0] mem [ROWS];
   logic [ROWS-1:0]              row_valid_ff;
   logic [lge_pkg::MAX_WIDTH-1:0] q_ff, rowq;
   logic                         qvalid_ff;
   logic [lge_pkg::MAX_WIDTH-1:0] up_ff, mid_ff, dn_ff, nxt_ff;
   logic [lge_pkg::COL_BITS-1:0] x_ff, xl, xr;
   logic [lge_pkg::ROW_BITS-1:0] y_ff, yu, yd;
   logic [lge_pkg::CNT_BITS-1:0] changes_ff;
   logic [19:0]                  scaled_ff, c20;
   logic [15:0]                  area_ff;
   logic [lge_pkg::ADDR_BITS-1:0] rd_addr, wr_addr;
   logic [lge_pkg::MAX_WIDTH-1:0] wr_data;
   logic                         wr_en, in_range, alive, next_cell;
   logic [3:0]                   ncount;
   logic                         rsp_valid_ff;
   lge_pkg::rsp_type             rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 8'd128;
         height_ff <= 8'd72;
      end else if (csr_write_enable) begin
         case (csr_index)
            lge_pkg::CSR_GRID_WIDTH:  width_ff <= csr_write_data;
            lge_pkg::CSR_GRID_HEIGHT: height_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff < 8'(lge_pkg::MIN_DIM)) w = 8'(lge_pkg::MIN_DIM);
      else if (width_ff > 8'(lge_pkg::MAX_WIDTH)) w = 8'(lge_pkg::MAX_WIDTH);
      else w = width_ff;
      if (height_ff < 8'(lge_pkg::MIN_DIM)) h = 8'(lge_pkg::MIN_DIM);
      else if (height_ff > 8'(lge_pkg::MAX_HEIGHT)) h = 8'(lge_pkg::MAX_HEIGHT);
      else h = height_ff;
   end

   // neighbor positions with wrap-around
   always_comb begin
      xl = (x_ff == '0) ? 7'(w - 8'd1) : x_ff - 7'd1;
      xr = ({1'b0, x_ff} == w - 8'd1) ? '0 : x_ff + 7'd1;
      yu = (y_ff == '0) ? 7'(h - 8'd1) : y_ff - 7'd1;
      yd = ({1'b0, y_ff} == h - 8'd1) ? '0 : y_ff + 7'd1;
   end

   assign rowq = qvalid_ff ? q_ff : '0;
   assign in_range = ({1'b0, req_ff.col} < w) && ({1'b0, req_ff.row} < h);

   always_comb begin
      case (cmd.rd_sel)
         lge_pkg::RSEL_ACCESS: rd_addr = {bank_ff, req_payload.row};
         lge_pkg::RSEL_UP:     rd_addr = {bank_ff, yu};
         lge_pkg::RSEL_MID:    rd_addr = {bank_ff, y_ff};
         lge_pkg::RSEL_DN:     rd_addr = {bank_ff, yd};
         lge_pkg::RSEL_DST:    rd_addr = {~bank_ff, y_ff};
         default:              rd_addr = {bank_ff, y_ff};
      endcase
   end

   always_comb begin
      wr_data = rowq;
      wr_data[req_ff.col] = req_ff.cell_in;
      wr_addr = {bank_ff, req_ff.row};
      wr_en = cmd.acc_wr && in_range && (req_ff.operation == lge_pkg::OP_LOAD);
      if (cmd.row_wr) begin
         wr_data = nxt_ff;
         wr_addr = {~bank_ff, y_ff};
         wr_en = 1'b1;
      end
   end

   // row store with per-row valid bits; an unwritten row reads as dead
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         qvalid_ff <= 1'b0;
      end else begin
         if (wr_en) row_valid_ff[wr_addr] <= 1'b1;
         if (cmd.rd_en) qvalid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_comb begin
      alive = mid_ff[x_ff];
      ncount = 4'(up_ff[xl]) + 4'(up_ff[x_ff]) + 4'(up_ff[xr])
             + 4'(mid_ff[xl]) + 4'(mid_ff[xr])
             + 4'(dn_ff[xl]) + 4'(dn_ff[x_ff]) + 4'(dn_ff[xr]);
      next_cell = (ncount == 4'd3) || (alive && ncount == 4'd2);
   end

   always_ff @(posedge clock) begin
      case (cmd.cap_sel)
         lge_pkg::CAP_UP:  up_ff <= rowq;
         lge_pkg::CAP_MID: mid_ff <= rowq;
         lge_pkg::CAP_DN:  dn_ff <= rowq;
         lge_pkg::CAP_DST: nxt_ff <= rowq;
         default: begin
         end
      endcase
      if (cmd.cell_en) nxt_ff[x_ff] <= next_cell;
      if (cmd.req_take) req_ff <= req_payload;
   end

   assign c20 = {5'b0, changes_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         x_ff <= '0;
         y_ff <= '0;
         changes_ff <= '0;
      end else begin
         if (cmd.req_take) begin
            x_ff <= '0;
            y_ff <= '0;
            changes_ff <= '0;
         end
         if (cmd.cell_en) begin
            x_ff <= x_ff + 7'd1;
            if (next_cell != alive) changes_ff <= changes_ff + 15'd1;
         end
         if (cmd.row_wr) begin
            x_ff <= '0;
            y_ff <= y_ff + 7'd1;
         end
         if (cmd.scale_en) bank_ff <= ~bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_en) begin
         scaled_ff <= (c20 << 5) + (c20 << 4) + (c20 << 1);
         area_ff <= {8'b0, w} * {8'b0, h};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.operation)
         lge_pkg::OP_READ: rsp_in.read_value = in_range && rowq[req_ff.col];
         lge_pkg::OP_STEP: begin
            rsp_in.change_count = changes_ff;
            rsp_in.reseed_wanted = scaled_ff < {4'b0, area_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign sts.req_op = req_payload.operation;
   assign sts.x_last = ({1'b0, x_ff} == w - 8'd1);
   assign sts.y_last = ({1'b0, y_ff} == h - 8'd1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/life_generation_engine_top.sv @@
// Toroidal Game of Life engine: top level joining controller and datapath.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
// Cells live in a two-bank row memory (one 128-bit row per word); a load or a
// read passes through an access state and then a response state that waits on
// output backpressure. A step works row by row: four row reads, one after the
// other through the single read port (above, own, below, destination), then
// one cell a cycle, then one row write. Per-row valid bits make every cell read
// as dead after reset, so no clearing pass is needed.
module life_generation_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lge_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lge_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [7:0]       csr_write_data
);

   lge_pkg::cmd_type cmd;
   lge_pkg::sts_type sts;

   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lge_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule
